### hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

### hdl/mbe_pkg.sv
package mbe_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_BITS  = 28;
  localparam int SUM_W      = 48;

  localparam int MAX_COLS_DEF = 4096;
  localparam int MAX_ROWS_DEF = 4096;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN      = 3'd0,
    REG_Y_MAX      = 3'd1,
    REG_X_STEP     = 3'd2,
    REG_Y_STEP     = 3'd3,
    REG_ITER_LIMIT = 3'd4,
    REG_BAILOUT_SQ = 3'd5,
    REG_NUM_COLORS = 3'd6
  } cfg_idx_t;

  localparam logic [31:0] X_MIN_RST      = 32'hE199_999A; // -1.9
  localparam logic [31:0] Y_MAX_RST      = 32'h1199_9999; // 1.1
  localparam logic [30:0] X_STEP_RST     = 31'd2621440;
  localparam logic [30:0] Y_STEP_RST     = 31'd2952790;
  localparam logic [15:0] ITER_LIMIT_RST = 16'd1024;
  localparam logic [31:0] BAILOUT_SQ_RST = 32'h4000_0000; // 4.0
  localparam logic [5:0]  NUM_COLORS_RST = 6'd6;

  typedef struct packed {
    logic [31:0] x_min;
    logic [31:0] y_max;
    logic [30:0] x_step;
    logic [30:0] y_step;
    logic [15:0] iter_limit;
    logic [31:0] bailout_sq;
    logic [5:0]  num_colors;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MCR,
    ST_MCI,
    ST_INIT,
    ST_SQR,
    ST_SQI,
    ST_MRI,
    ST_CHK,
    ST_WAIT
  } state_t;

  // clamp a wide signed sum to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sd2147483647);
    lo = -hi - SUM_W'(64'sd1);
    if (v > hi) begin
      return hi[31:0];
    end else if (v < lo) begin
      return lo[31:0];
    end
    return v[31:0];
  endfunction

endpackage

### hdl/mbe_cfg_regs.sv
module mbe_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data,
  output mbe_pkg::cfg_t                  cfg
);

  mbe_pkg::cfg_t cfg_r;
  mbe_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        mbe_pkg::REG_X_MIN:      cfg_nxt.x_min      = cfg_data;
        mbe_pkg::REG_Y_MAX:      cfg_nxt.y_max      = cfg_data;
        mbe_pkg::REG_X_STEP:     cfg_nxt.x_step     = cfg_data[30:0];
        mbe_pkg::REG_Y_STEP:     cfg_nxt.y_step     = cfg_data[30:0];
        mbe_pkg::REG_ITER_LIMIT: cfg_nxt.iter_limit = cfg_data[15:0];
        mbe_pkg::REG_BAILOUT_SQ: cfg_nxt.bailout_sq = cfg_data;
        mbe_pkg::REG_NUM_COLORS: cfg_nxt.num_colors = cfg_data[5:0];
        default: ; // unknown index: drop the word
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_min      <= mbe_pkg::X_MIN_RST;
      cfg_r.y_max      <= mbe_pkg::Y_MAX_RST;
      cfg_r.x_step     <= mbe_pkg::X_STEP_RST;
      cfg_r.y_step     <= mbe_pkg::Y_STEP_RST;
      cfg_r.iter_limit <= mbe_pkg::ITER_LIMIT_RST;
      cfg_r.bailout_sq <= mbe_pkg::BAILOUT_SQ_RST;
      cfg_r.num_colors <= mbe_pkg::NUM_COLORS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/mbe_mul.sv
// Shared signed 32x32 multiplier, product registered.
module mbe_mul (
  input  logic               clk,
  input  logic signed [31:0] mul_a,
  input  logic signed [31:0] mul_b,
  output logic signed [63:0] mul_p
);

  logic signed [63:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
  end

  assign mul_p = p_r;

endmodule

### hdl/mandelbrot_escape_time_pixel.sv
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    in_pixel_row[11:0], in_pixel_col[11:0]
// out      output     out_valid/out_stall  out_color_index[5:0]
// cfg      input      cfg_we               cfg_index[2:0], cfg_data[31:0]
//
// A pixel runs k iterations (1 to the iteration limit) and then waits for a free
// output register; one shared multiplier does three products per iteration and
// both coordinate products. An iteration limit of zero gives colour 0 with no
// iterations run.
// Reset: synchronous, active low; control and cfg registers take defaults.
// in_stall is high from acceptance until the result is in the output
// register; a stalled output word holds and blocks only the next result.
`include "assert_macros.svh"

module mandelbrot_escape_time_pixel #(
  parameter int MAX_COLS = mbe_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = mbe_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [11:0]                    in_pixel_row,
  input  logic [11:0]                    in_pixel_col,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [5:0]                     out_color_index,
  input  logic                           cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int          SW      = mbe_pkg::SUM_W;
  localparam int          FB      = mbe_pkg::FRAC_BITS;
  localparam logic [16:0] COL_LIM = 17'(MAX_COLS - 1);
  localparam logic [16:0] ROW_LIM = 17'(MAX_ROWS - 1);

  mbe_pkg::cfg_t cfg;

  mbe_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;

  mbe_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  mbe_pkg::state_t    state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [5:0]         out_color_r, out_color_nxt;
  logic [11:0]        row_r, row_nxt;
  logic [11:0]        col_r, col_nxt;
  logic signed [31:0] cr_r, cr_nxt;
  logic signed [31:0] ci_r, ci_nxt;
  logic signed [31:0] zr_r, zr_nxt;
  logic signed [31:0] zi_r, zi_nxt;
  logic [63:0]        rr_r, rr_nxt;
  logic signed [63:0] d_r, d_nxt;
  logic               esc_r, esc_nxt;
  logic [15:0]        iter_r, iter_nxt;
  logic [5:0]         cc_r, cc_nxt;
  logic [5:0]         res_r, res_nxt;

  logic [64:0]        mag;
  logic [64:0]        limit;
  logic               last_iter;
  logic               out_free;
  logic [6:0]         cc_inc;

  assign mag       = {1'b0, rr_r} + {1'b0, mul_p};
  assign limit     = {5'd0, cfg.bailout_sq, {FB{1'b0}}};
  assign last_iter = ({1'b0, iter_r} + 17'd1) == {1'b0, cfg.iter_limit};
  assign out_free  = !out_valid_r || !out_stall;
  assign cc_inc    = {1'b0, cc_r} + 7'd1;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_color_nxt = out_color_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    rr_nxt        = rr_r;
    d_nxt         = d_r;
    esc_nxt       = esc_r;
    iter_nxt      = iter_r;
    cc_nxt        = cc_r;
    res_nxt       = res_r;
    mul_a         = '0;
    mul_b         = '0;
    in_stall      = (state_r != mbe_pkg::ST_IDLE);

    case (state_r)
      mbe_pkg::ST_IDLE: begin
        if (in_valid) begin
          row_nxt  = ({5'd0, in_pixel_row} > ROW_LIM) ? ROW_LIM[11:0] : in_pixel_row;
          col_nxt  = ({5'd0, in_pixel_col} > COL_LIM) ? COL_LIM[11:0] : in_pixel_col;
          iter_nxt = '0;
          cc_nxt   = '0;
          if (cfg.iter_limit == 16'd0) begin
            res_nxt   = '0;
            state_nxt = mbe_pkg::ST_WAIT;
          end else begin
            state_nxt = mbe_pkg::ST_MCR;
          end
        end
      end
      mbe_pkg::ST_MCR: begin
        mul_a     = $signed({20'd0, col_r});
        mul_b     = $signed({1'b0, cfg.x_step});
        state_nxt = mbe_pkg::ST_MCI;
      end
      mbe_pkg::ST_MCI: begin
        cr_nxt    = mbe_pkg::sat32($signed({{(SW-32){cfg.x_min[31]}}, cfg.x_min})
                                   + $signed(mul_p[SW-1:0]));
        mul_a     = $signed({20'd0, row_r});
        mul_b     = $signed({1'b0, cfg.y_step});
        state_nxt = mbe_pkg::ST_INIT;
      end
      mbe_pkg::ST_INIT: begin
        // first step from z = 0 gives z = c
        ci_nxt    = mbe_pkg::sat32($signed({{(SW-32){cfg.y_max[31]}}, cfg.y_max})
                                   - $signed(mul_p[SW-1:0]));
        zr_nxt    = cr_r;
        zi_nxt    = ci_nxt;
        state_nxt = mbe_pkg::ST_SQR;
      end
      mbe_pkg::ST_SQR: begin
        mul_a     = zr_r;
        mul_b     = zr_r;
        state_nxt = mbe_pkg::ST_SQI;
      end
      mbe_pkg::ST_SQI: begin
        rr_nxt    = mul_p;
        mul_a     = zi_r;
        mul_b     = zi_r;
        state_nxt = mbe_pkg::ST_MRI;
      end
      mbe_pkg::ST_MRI: begin
        esc_nxt   = mag > limit;
        d_nxt     = $signed(rr_r) - mul_p;
        mul_a     = zr_r;
        mul_b     = zi_r;
        state_nxt = mbe_pkg::ST_CHK;
      end
      mbe_pkg::ST_CHK: begin
        if (esc_r || last_iter) begin
          res_nxt   = (cfg.num_colors == 6'd0) ? 6'd0 : cc_r;
          state_nxt = mbe_pkg::ST_WAIT;
        end else begin
          // floor shifts: take the upper bits with the sign carried
          zr_nxt    = mbe_pkg::sat32($signed({{(SW-64+FB){d_r[63]}}, d_r[63:FB]})
                                     + $signed({{(SW-32){cr_r[31]}}, cr_r}));
          zi_nxt    = mbe_pkg::sat32($signed({{(SW-65+FB){mul_p[63]}}, mul_p[63:FB-1]})
                                     + $signed({{(SW-32){ci_r[31]}}, ci_r}));
          iter_nxt  = iter_r + 16'd1;
          cc_nxt    = (cc_inc == {1'b0, cfg.num_colors}) ? 6'd0 : cc_inc[5:0];
          state_nxt = mbe_pkg::ST_SQR;
        end
      end
      mbe_pkg::ST_WAIT: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_color_nxt = res_r;
          state_nxt     = mbe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mbe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbe_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_color_r <= out_color_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    cr_r        <= cr_nxt;
    ci_r        <= ci_nxt;
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    rr_r        <= rr_nxt;
    d_r         <= d_nxt;
    esc_r       <= esc_nxt;
    iter_r      <= iter_nxt;
    cc_r        <= cc_nxt;
    res_r       <= res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_color_r;

  `ASSERT_PROP(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall)
  `ASSERT_NEVER(a_iter_in_range, clk, rst_n, (state_r == mbe_pkg::ST_CHK) && (iter_r >= cfg.iter_limit))
  `ASSERT_NEVER(a_colour_wrap, clk, rst_n, (state_r == mbe_pkg::ST_CHK) && (cfg.num_colors != 6'd0) && (cc_r >= cfg.num_colors))
  `ASSERT_PROP(a_out_in_palette, clk, rst_n, out_valid_r |-> ((cfg.num_colors == 6'd0) && (out_color_r == 6'd0)) || (out_color_r < cfg.num_colors))

endmodule
